// ===== rtl/ipc_pkg.sv =====
// shared types and constants for the integer property classifier
// no dependencies; imported by ipc_div and integer_property_classifier
`default_nettype none

package ipc_pkg;

	// default width of the value to classify
	localparam int VALUE_BITS_DEF = 8;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_FAC_SETUP,
		ST_FAC_START,
		ST_FAC_WAIT,
		ST_REP_START,
		ST_REP_WAIT,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/ipc_div.sv =====
// restoring divider, one quotient bit per cycle, shared by all classifier passes
// depends on ipc_pkg for the default width
`default_nettype none

module ipc_div
	import ipc_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [VALUE_BITS-1:0] dividend,
	input  wire logic [VALUE_BITS-1:0] divisor,
	output logic                       done,
	output logic [VALUE_BITS-1:0]      quotient,
	output logic [VALUE_BITS-1:0]      remainder
);

	localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] dsr_q;

	logic [VALUE_BITS:0]   trial;
	logic [VALUE_BITS:0]   diff;
	logic                  take;

	// one restoring step: shift in next dividend bit, try subtract
	assign trial = {rem_q, quo_q[VALUE_BITS-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign take  = (trial >= {1'b0, dsr_q});

	// control: busy for VALUE_BITS steps, then a done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
			quo_q <= {quo_q[VALUE_BITS-2:0], take};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== rtl/integer_property_classifier.sv =====
// top level of the integer property classifier: sequencer and flag datapath
// depends on ipc_pkg and ipc_div
`default_nettype none

// Classifies one unsigned value per item and returns four flags: perfect (proper
// divisor sum equals the value), prime, perfect square and sphenic (product of
// three distinct primes); a value of 0 gives all flags low and 1 is only square.
// All tests run on a single restoring divider, each division started from its
// own issue state. The divisor pass tries every d in 1..v-1, and the factoring
// pass tries p from 2 upward while p stays within the remaining cofactor, with
// one extra division per prime factor found. Values 0 and 1 skip both passes.
// in_ready is high only while the sequencer is idle; a finished result sits in
// the output register while the next item is taken.

module integer_property_classifier
	import ipc_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [VALUE_BITS-1:0] value,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       is_perfect,
	output logic                       is_prime,
	output logic                       is_square,
	output logic                       is_sphenic
);

	localparam int SUM_BITS = VALUE_BITS + 1;

	state_t state_q, state_d;

	logic [VALUE_BITS-1:0] v_q;
	logic [VALUE_BITS-1:0] d_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic                  found_q;
	logic                  sq_q;
	logic [VALUE_BITS-1:0] rest_q;
	logic [VALUE_BITS:0]   p_q;
	logic [2:0]            fac_q;
	logic                  rep_q;
	logic                  out_valid_q;
	logic                  perfect_q, prime_q, square_q, sphenic_q;

	logic                  accept;
	logic                  div_start;
	logic [VALUE_BITS-1:0] div_dividend;
	logic [VALUE_BITS-1:0] div_divisor;
	logic                  div_done;
	logic [VALUE_BITS-1:0] div_quo;
	logic [VALUE_BITS-1:0] div_rem;
	logic                  out_free;
	logic                  load_out;
	logic                  rem_zero;
	logic                  p_over;
	logic [SUM_BITS:0]     sum_next;

	// shared divider
	ipc_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	assign rem_zero = (div_rem == '0);
	assign p_over   = (p_q > {1'b0, rest_q});
	assign out_free = !out_valid_q || out_ready;
	assign sum_next = {1'b0, sum_q} + {{(SUM_BITS - VALUE_BITS + 1){1'b0}}, d_q};

	// divider operands follow the active pass
	always_comb begin
		if (state_q == ST_DIV_START) begin
			div_dividend = v_q;
			div_divisor  = d_q;
		end else begin
			div_dividend = rest_q;
			div_divisor  = p_q[VALUE_BITS-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (value < VALUE_BITS'(2)) ? ST_FINISH : ST_DIV_START;
				end
			end
			ST_DIV_START: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = (d_q == v_q - 1'b1) ? ST_FAC_SETUP : ST_DIV_START;
				end
			end
			ST_FAC_SETUP: state_d = ST_FAC_START;
			ST_FAC_START: state_d = p_over ? ST_FINISH : ST_FAC_WAIT;
			ST_FAC_WAIT: begin
				if (div_done) begin
					state_d = rem_zero ? ST_REP_START : ST_FAC_START;
				end
			end
			ST_REP_START: state_d = ST_REP_WAIT;
			ST_REP_WAIT: begin
				if (div_done) begin
					state_d = rem_zero ? ST_FINISH : ST_FAC_START;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE:      in_ready  = 1'b1;
			ST_DIV_START: div_start = 1'b1;
			ST_FAC_START: div_start = !p_over;
			ST_REP_START: div_start = 1'b1;
			ST_FINISH:    load_out  = out_free;
			default: ;
		endcase
	end

	assign accept = in_valid && in_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// divisor pass: divisor sum, prime and square evidence
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q     <= value;
			d_q     <= VALUE_BITS'(1);
			sum_q   <= '0;
			found_q <= 1'b0;
			sq_q    <= 1'b0;
		end else if (state_q == ST_DIV_WAIT && div_done) begin
			if (rem_zero) begin
				sum_q <= sum_next[SUM_BITS] ? '1 : sum_next[SUM_BITS-1:0];
				if (d_q != VALUE_BITS'(1)) begin
					found_q <= 1'b1;
				end
				if (div_quo == d_q) begin
					sq_q <= 1'b1;
				end
			end
			d_q <= d_q + 1'b1;
		end
	end

	// factoring pass: distinct prime count and repeated factor
	always_ff @(posedge clk) begin
		if (accept) begin
			fac_q <= '0;
			rep_q <= 1'b0;
		end else if (state_q == ST_FAC_SETUP) begin
			rest_q <= v_q;
			p_q    <= (VALUE_BITS + 1)'(2);
		end else if (state_q == ST_FAC_WAIT && div_done) begin
			if (rem_zero) begin
				rest_q <= div_quo;
				if (fac_q != 3'd4) begin
					fac_q <= fac_q + 1'b1;
				end
			end else begin
				p_q <= p_q + 1'b1;
			end
		end else if (state_q == ST_REP_WAIT && div_done) begin
			if (rem_zero) begin
				rep_q <= 1'b1;
			end else begin
				p_q <= p_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			perfect_q <= (v_q != '0) && (sum_q == {1'b0, v_q});
			prime_q   <= (v_q >= VALUE_BITS'(2)) && !found_q;
			square_q  <= (v_q == VALUE_BITS'(1)) || ((v_q >= VALUE_BITS'(2)) && sq_q);
			sphenic_q <= (v_q >= VALUE_BITS'(2)) && (fac_q == 3'd3) && !rep_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign is_perfect = perfect_q;
	assign is_prime   = prime_q;
	assign is_square  = square_q;
	assign is_sphenic = sphenic_q;

	// a taken item keeps in_ready low in the cycle after it is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("in_ready high right after an item was taken");

	// the divider is only started from an issue state
	a_div_start_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (state_q == ST_DIV_START || state_q == ST_FAC_START ||
			state_q == ST_REP_START))
		else $error("divider started outside an issue state");

	// a prime is never also square, perfect or sphenic
	a_prime_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_prime) |-> (!is_square && !is_perfect && !is_sphenic))
		else $error("prime flag set together with another flag");

	// a new result is only loaded into a free output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending item");

endmodule

`default_nettype wire
